@@ design/cosine_distance_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cosine distance core
// Concurrent checks on the core clock, off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef COSINE_DISTANCE_CORE_MACROS_SVH
`define COSINE_DISTANCE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cosine_distance_core: check failed");

// next-cycle implication
`define CDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cosine_distance_core: check failed");

`else

`define CDC_ASSERT_SAME(lbl, ante, cons)
`define CDC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/cosd_pkg.sv @@
// ----------------------------------------------------------------------------
// cosd_pkg
// Shared widths, constants and the command/status bundles of the core.
// ----------------------------------------------------------------------------
package cosd_pkg;

    localparam int ACC_W   = 48;   // accumulator width
    localparam int HALF_W  = 24;   // operand half for the shared multiplier
    localparam int PROD_W  = 96;   // full norm product / squared dot
    localparam int CMP_W   = 128;  // search compare width
    localparam int G_W     = 111;  // running m * P
    localparam int M_W     = 15;   // search result bits
    localparam int T_SHIFT = 28;   // Q14 squared scale on dot^2

    localparam logic [15:0]    ONE_Q14   = 16'd16384;
    localparam logic [15:0]    Q_SAT_POS = 16'd16383;
    localparam logic [3:0]     SRCH_TOP  = 4'd14;
    localparam logic [2:0]     STEP_LAST = 3'd7;

    typedef struct packed {
        logic       acc_en;    // add the accepted pair into the accumulators
        logic       mul_clr;   // clear product and search registers
        logic       mul_en;    // issue one partial product
        logic [2:0] mul_step;  // [2]: 0 norm product, 1 dot square; [1:0] halves
        logic       srch_a;    // search phase A: F + G * 2^(k+1)
        logic       srch_b;    // search phase B: add P * 2^2k, compare, update
        logic [3:0] srch_bit;  // bit under trial
        logic       finish;    // load result, clear accumulators
    } t_cmd;

    typedef struct packed {
        logic out_free;        // output register can take a result now
    } t_sts;

endpackage

@@ design/cosd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cosd_ctrl
// Sequencer: accumulate, multiply steps, bitwise search, result handoff.
// ----------------------------------------------------------------------------
module cosd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_s_tlast,
    output logic            o_s_tready,
    input  cosd_pkg::t_sts  i_sts,
    output cosd_pkg::t_cmd  o_cmd
);

`include "cosine_distance_core_macros.svh"

    typedef enum logic [5:0] {
        S_ACC   = 6'b000001,
        S_MUL   = 6'b000010,
        S_DRAIN = 6'b000100,
        S_SRA   = 6'b001000,
        S_SRB   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic [3:0] r_bit, n_bit;
    logic       accept;

    assign o_s_tready = (r_state == S_ACC);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.mul_step = r_step;
        o_cmd.srch_bit = r_bit;
        unique case (r_state)
            S_ACC: begin
                o_cmd.acc_en  = accept;
                o_cmd.mul_clr = accept && i_s_tlast;
                if (accept && i_s_tlast) begin
                    n_state = S_MUL;
                    n_step  = 3'd0;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_step       = r_step + 3'd1;
                if (r_step == cosd_pkg::STEP_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SRA;
                n_bit   = cosd_pkg::SRCH_TOP;
            end
            S_SRA: begin
                o_cmd.srch_a = 1'b1;
                n_state      = S_SRB;
            end
            S_SRB: begin
                o_cmd.srch_b = 1'b1;
                if (r_bit == 4'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_bit   = r_bit - 4'd1;
                    n_state = S_SRA;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= 3'd0;
            r_bit   <= 4'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bit   <= n_bit;
        end
    end

    // a vector end starts the multiply sequence at its first step
    `CDC_ASSERT_NEXT(a_mul_start, o_cmd.mul_clr, o_cmd.mul_en && (o_cmd.mul_step == 3'd0))
    // every phase A is followed by its phase B on the same bit
    `CDC_ASSERT_NEXT(a_srch_pair, o_cmd.srch_a, o_cmd.srch_b && $stable(o_cmd.srch_bit))
    // no pair is taken while a vector is being finished
    `CDC_ASSERT_SAME(a_acc_idle, o_cmd.acc_en, !o_cmd.mul_en && !o_cmd.srch_b)

endmodule

@@ design/cosd_dp.sv @@
// ----------------------------------------------------------------------------
// cosd_dp
// Accumulators, shared 24x24 multiplier, bitwise ratio search, output stage.
// ----------------------------------------------------------------------------
module cosd_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cosd_pkg::t_cmd  i_cmd,
    output cosd_pkg::t_sts  o_sts,
    input  logic [31:0]     i_s_tdata,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [15:0]     o_m_tdata,
    output logic            o_m_tuser
);

`include "cosine_distance_core_macros.svh"

    localparam int AW = cosd_pkg::ACC_W;
    localparam int HW = cosd_pkg::HALF_W;
    localparam int PW = cosd_pkg::PROD_W;
    localparam int CW = cosd_pkg::CMP_W;
    localparam int GW = cosd_pkg::G_W;
    localparam int MW = cosd_pkg::M_W;

    // element products
    logic signed [15:0] a_elem, b_elem;
    logic signed [31:0] p_ab, p_aa, p_bb;

    assign a_elem = signed'(i_s_tdata[15:0]);
    assign b_elem = signed'(i_s_tdata[31:16]);
    assign p_ab   = a_elem * b_elem;
    assign p_aa   = a_elem * a_elem;
    assign p_bb   = b_elem * b_elem;

    logic [AW-1:0] r_dot, r_na, r_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (i_cmd.acc_en) begin
            r_dot <= r_dot + AW'(p_ab);
            r_na  <= r_na + AW'(p_aa);
            r_nb  <= r_nb + AW'(p_bb);
        end
    end

    // sign and magnitude of the dot product
    logic          neg, zero_norm, mag_zero;
    logic [AW-1:0] mag;

    assign neg       = r_dot[AW-1];
    assign mag       = neg ? (~r_dot + AW'(1)) : r_dot;
    assign mag_zero  = (r_dot == '0);
    assign zero_norm = (r_na == '0) || (r_nb == '0);

    // shared multiplier: four partial products per 48x48 result
    logic [AW-1:0]   mx, my;
    logic [HW-1:0]   mx_h, my_h;
    logic [2*HW-1:0] r_pp;
    logic [2:0]      r_pp_sel;
    logic            r_pp_vld;
    logic [1:0]      pp_pos;
    logic [PW-1:0]   pp_ext;
    logic [PW-1:0]   r_p, r_t;

    assign mx   = i_cmd.mul_step[2] ? mag : r_na;
    assign my   = i_cmd.mul_step[2] ? mag : r_nb;
    assign mx_h = i_cmd.mul_step[1] ? mx[AW-1:HW] : mx[HW-1:0];
    assign my_h = i_cmd.mul_step[0] ? my[AW-1:HW] : my[HW-1:0];

    assign pp_pos = {1'b0, r_pp_sel[1]} + {1'b0, r_pp_sel[0]};

    always_comb begin
        case (pp_pos)
            2'd0:    pp_ext = PW'(r_pp);
            2'd1:    pp_ext = PW'(r_pp) << HW;
            default: pp_ext = PW'(r_pp) << (2 * HW);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
        end else begin
            r_pp_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp     <= mx_h * my_h;
        r_pp_sel <= i_cmd.mul_step;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_clr) begin
            r_p <= '0;
            r_t <= '0;
        end else if (r_pp_vld) begin
            if (r_pp_sel[2]) begin
                r_t <= r_t + pp_ext;
            end else begin
                r_p <= r_p + pp_ext;
            end
        end
    end

    // bitwise search on m: F = m^2 * P, G = m * P
    logic [MW-1:0] r_m;
    logic [CW-1:0] r_f, r_s;
    logic [GW-1:0] r_g;
    logic [CW-1:0] cand, t_scaled;
    logic          take;

    assign cand     = r_s + (CW'(r_p) << {i_cmd.srch_bit, 1'b0});
    assign t_scaled = CW'({r_t, cosd_pkg::T_SHIFT'(0)});
    assign take     = neg ? (cand <= t_scaled) : (cand < t_scaled);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_clr) begin
            r_m <= '0;
            r_f <= '0;
            r_g <= '0;
        end else if (i_cmd.srch_b && take) begin
            r_m <= r_m | (MW'(1) << i_cmd.srch_bit);
            r_f <= cand;
            r_g <= r_g + (GW'(r_p) << i_cmd.srch_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_a) begin
            r_s <= r_f + (CW'(r_g) << ({1'b0, i_cmd.srch_bit} + 5'd1));
        end
    end

    // result mapping
    logic [15:0] q16, dist_val;

    assign q16 = {1'b0, r_m};

    always_comb begin
        if (zero_norm) begin
            dist_val = '0;
        end else if (mag_zero) begin
            dist_val = cosd_pkg::ONE_Q14;
        end else if (neg) begin
            dist_val = cosd_pkg::ONE_Q14
                     + ((q16 > cosd_pkg::ONE_Q14) ? cosd_pkg::ONE_Q14 : q16);
        end else if (q16 >= cosd_pkg::Q_SAT_POS) begin
            dist_val = '0;
        end else begin
            dist_val = cosd_pkg::Q_SAT_POS - q16;
        end
    end

    // output register
    logic        r_out_vld;
    logic [15:0] r_out_dist;
    logic        r_out_zn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_dist <= dist_val;
            r_out_zn   <= zero_norm;
        end
    end

    assign o_sts.out_free = !r_out_vld || i_m_tready;
    assign o_m_tvalid     = r_out_vld;
    assign o_m_tdata      = r_out_dist;
    assign o_m_tuser      = r_out_zn;

    // never overwrite a result that has not been taken
    `CDC_ASSERT_SAME(a_no_overwrite, i_cmd.finish, !r_out_vld || i_m_tready)
    // a finished vector always shows a result next cycle
    `CDC_ASSERT_NEXT(a_finish_out, i_cmd.finish, o_m_tvalid)
    // zero norm forces a zero distance, and distance stays within 0..2.0
    `CDC_ASSERT_SAME(a_zn_dist, o_m_tvalid && o_m_tuser, o_m_tdata == 16'd0)
    `CDC_ASSERT_SAME(a_dist_rng, o_m_tvalid, o_m_tdata <= 16'd32768)

endmodule

@@ design/cosine_distance_core.sv @@
// ----------------------------------------------------------------------------
// cosine_distance_core
// Sequence after the edge that accepts the last pair: 8 multiply steps, 1 drain,
// 15 search bits (phase A and phase B each), 1 handoff to the output register.
// Throughput: one pair per cycle within a vector; the sequencer holds tready low
// from each last pair through that sequence, longer while an earlier result still waits.
// Reset (i_rst_n, synchronous, active low) clears the accumulators, sequencer
// and output valid; the core is ready to take pairs on the first cycle after it.
// ----------------------------------------------------------------------------
module cosine_distance_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] a_elem, [31:16] b_elem
    input  logic        i_s_tlast,   // is_last
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] distance (unsigned Q2.14)
    output logic        o_m_tuser    // [0] zero_norm
);

    // The controller owns the handshake on the input side and sequences the
    // datapath with one command bundle per cycle. The datapath keeps the three
    // 48-bit accumulators, a single 24x24 multiplier that builds the norm product
    // and the squared dot over eight steps, and a bit-at-a-time search for
    // m = 16384 * |cos| using only shifts, adds and one compare per bit.
    cosd_pkg::t_cmd cmd;
    cosd_pkg::t_sts sts;

    cosd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Result register sits in the datapath; the controller waits in its
    // handoff state only while the previous result is still held.
    cosd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

@@ tb/cosine_distance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_distance_checker
// Watches both streams of the cosine distance core. It predicts the distance
// and zero-norm flag of every finished vector and compares each result item,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cosine_distance_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] a_elem, [31:16] b_elem
    input  logic        i_s_tlast,   // is_last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // [15:0] distance
    input  logic        i_m_tuser,   // [0] zero_norm
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] distance;
        logic        zero_norm;
    } t_dist_result;

    logic [cosd_pkg::ACC_W-1:0] dot_sum    = '0;
    logic [cosd_pkg::ACC_W-1:0] norm_a_sum = '0;
    logic [cosd_pkg::ACC_W-1:0] norm_b_sum = '0;
    t_dist_result               expected_distances[$];
    int                         mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Exact 1 - dot / sqrt(na * nb) in Q2.14, floored and clipped to 0..2.
    function automatic t_dist_result predict_distance(
        input logic [cosd_pkg::ACC_W-1:0] dot,
        input logic [cosd_pkg::ACC_W-1:0] na,
        input logic [cosd_pkg::ACC_W-1:0] nb);
        t_dist_result               r;
        logic [cosd_pkg::ACC_W-1:0] mag;
        logic [127:0]               norm_prod, dot_sq, trial, m_sq;
        logic [31:0]                lo, hi, mid;
        r.distance  = '0;
        r.zero_norm = 1'b0;
        if (na == '0 || nb == '0) begin
            r.zero_norm = 1'b1;
            return r;
        end
        mag       = dot[cosd_pkg::ACC_W-1] ? (~dot + 1'b1) : dot;
        norm_prod = 128'(na) * 128'(nb);
        dot_sq    = (128'(mag) * 128'(mag)) << cosd_pkg::T_SHIFT;
        if (mag == '0) begin
            r.distance = cosd_pkg::ONE_Q14;
        end else if (!dot[cosd_pkg::ACC_W-1]) begin
            // smallest m with m^2 * P >= 2^28 * dot^2
            lo = 0;
            hi = cosd_pkg::ONE_Q14 + 1;
            while (lo < hi) begin
                mid   = (lo + hi) / 2;
                m_sq  = 128'(mid) * 128'(mid);
                trial = norm_prod * m_sq;
                if (trial >= dot_sq)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            r.distance = (lo >= cosd_pkg::ONE_Q14) ? 16'd0 : cosd_pkg::ONE_Q14 - lo[15:0];
        end else begin
            // largest m with m^2 * P <= 2^28 * dot^2
            lo = 0;
            hi = cosd_pkg::ONE_Q14;
            while (lo < hi) begin
                mid   = (lo + hi + 1) / 2;
                m_sq  = 128'(mid) * 128'(mid);
                trial = norm_prod * m_sq;
                if (trial <= dot_sq)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            r.distance = cosd_pkg::ONE_Q14 + lo[15:0];
        end
        return r;
    endfunction

    task automatic absorb_pair(input logic [31:0] data, input logic last);
        logic signed [15:0]                a, b;
        logic signed [cosd_pkg::ACC_W-1:0] ab, aa, bb;
        a  = data[15:0];
        b  = data[31:16];
        ab = cosd_pkg::ACC_W'(a) * cosd_pkg::ACC_W'(b);
        aa = cosd_pkg::ACC_W'(a) * cosd_pkg::ACC_W'(a);
        bb = cosd_pkg::ACC_W'(b) * cosd_pkg::ACC_W'(b);
        dot_sum    = dot_sum + ab;
        norm_a_sum = norm_a_sum + aa;
        norm_b_sum = norm_b_sum + bb;
        if (last) begin
            expected_distances.push_back(predict_distance(dot_sum, norm_a_sum, norm_b_sum));
            dot_sum    = '0;
            norm_a_sum = '0;
            norm_b_sum = '0;
        end
    endtask

    task automatic check_result(input logic [15:0] distance, input logic zero_norm);
        t_dist_result want;
        if (expected_distances.size() == 0) begin
            $error("unexpected result item: distance %0d zero_norm %0b", distance, zero_norm);
            mismatches++;
        end else begin
            want = expected_distances.pop_front();
            if (distance !== want.distance) begin
                $error("distance: expected %0d, actual %0d", want.distance, distance);
                mismatches++;
            end
            if (zero_norm !== want.zero_norm) begin
                $error("zero_norm: expected %0b, actual %0b", want.zero_norm, zero_norm);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                absorb_pair(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata, i_m_tuser);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_distances.size();
    end

endmodule

@@ tb/cosine_distance_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_distance_core_test
// Streams vector element pairs into the cosine distance core: a directed set
// of extremes, zero norms and orthogonal vectors, then about 1500 random pairs
// in vectors of assorted shapes, one of them at the design length and streamed
// without gaps. The sender idles in bursts and the receiver stalls on its own
// pattern; a separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module cosine_distance_core_test;

    localparam int          RANDOM_PAIRS  = 1500;
    localparam int          MAX_LENGTH    = 1024;
    localparam int          HOLD_CYCLES   = 600;  // long receiver hold-off
    localparam int          DRAIN_CYCLES  = 80;   // idle wait after the last result before the verdict
    localparam logic [15:0] POS_FULL      = 16'h7FFF;
    localparam logic [15:0] NEG_FULL      = 16'h8000;
    localparam logic [15:0] MINUS_ONE     = 16'hFFFF;

    // vector shapes used by the random part
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_SMALL,
        SHAPE_SAME,
        SHAPE_OPPOSITE,
        SHAPE_SCALED,
        SHAPE_EXTREMES,
        SHAPE_ZERO_A,
        SHAPE_ZERO_B,
        SHAPE_SPARSE
    } t_vec_shape;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending;

    int          burst_left = 0;  // items left in the current sender burst
    bit          steady     = 0;  // suppress sender gaps
    bit          hold_req   = 0;  // ask the receiver for one long hold-off

    cosine_distance_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    cosine_distance_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: several times the slowest legal run (every vector a single
    // pair, with the longest sender gaps, receiver stalls and the hold-off).
    initial begin
        #10_000_000;
        $display("cosine_distance_core_test failed");
        $finish;
    end

    // Offer one pair and hold it until the core takes it. Between bursts drop
    // tvalid for a random gap unless steady streaming is asked for.
    task automatic offer_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return NEG_FULL;
            1:       return MINUS_ONE;
            2:       return 16'd0;
            3:       return 16'd1;
            default: return POS_FULL;
        endcase
    endfunction

    // Send one vector of len pairs in the given shape, last pair flagged.
    task automatic send_vector(input int len, input t_vec_shape shape);
        logic [15:0] a, b;
        int          scale;
        scale = $urandom_range(1, 7) - 4;
        for (int i = 0; i < len; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (shape)
                SHAPE_SMALL: begin
                    a = 16'($urandom_range(0, 15) - 8);
                    b = 16'($urandom_range(0, 15) - 8);
                end
                SHAPE_SAME:     b = a;
                SHAPE_OPPOSITE: b = -a;
                SHAPE_SCALED: begin
                    a = 16'($urandom_range(0, 8191) - 4096);
                    b = 16'(a * scale);
                end
                SHAPE_EXTREMES: begin
                    a = pick_extreme();
                    b = pick_extreme();
                end
                SHAPE_ZERO_A: a = '0;
                SHAPE_ZERO_B: b = '0;
                SHAPE_SPARSE: begin
                    if ($urandom_range(0, 3) != 0) a = '0;
                    if ($urandom_range(0, 3) != 0) b = '0;
                end
                default: ;
            endcase
            offer_pair(a, b, i == len - 1);
        end
    endtask

    function automatic t_vec_shape pick_shape();
        case ($urandom_range(0, 15)) inside
            [0:4]:   return SHAPE_RANDOM;
            [5:6]:   return SHAPE_SMALL;
            7:       return SHAPE_SAME;
            8:       return SHAPE_OPPOSITE;
            [9:10]:  return SHAPE_SCALED;
            [11:12]: return SHAPE_EXTREMES;
            13:      return SHAPE_ZERO_A;
            14:      return SHAPE_ZERO_B;
            default: return SHAPE_SPARSE;
        endcase
    endfunction

    // Receiver: stall on a pattern of its own that changes every span, with
    // one long hold-off on request while the sender keeps offering.
    initial begin
        int          mode;
        int          span;
        logic [7:0]  pattern;
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            mode    = $urandom_range(0, 3);
            span    = $urandom_range(8, 64);
            pattern = 8'($urandom);
            for (int k = 0; k < span; k++) begin
                if (hold_req) begin
                    hold_req = 0;
                    m_tready <= 1'b0;
                    for (int h = 0; h < HOLD_CYCLES; h++) @(posedge i_clk);
                end else begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= pattern[3'(k)];
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int pairs_sent;
        int vectors;
        int len;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        i_rst_n  <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n  <= 1'b1;

        // Directed: full-scale parallel and antiparallel pairs
        offer_pair(POS_FULL, POS_FULL, 1'b1);
        offer_pair(NEG_FULL, NEG_FULL, 1'b1);
        offer_pair(POS_FULL, NEG_FULL, 1'b1);
        offer_pair(NEG_FULL, POS_FULL, 1'b1);
        // zero norm on A, on B and on both
        offer_pair(16'd0, 16'd1234, 1'b1);
        offer_pair(-16'sd5, 16'd0, 1'b1);
        offer_pair(16'd0, 16'd0, 1'b1);
        // orthogonal vectors: dot is zero, distance is exactly one
        offer_pair(16'd1, 16'd0, 1'b0);
        offer_pair(16'd0, MINUS_ONE, 1'b1);
        offer_pair(16'd1, 16'd1, 1'b0);
        offer_pair(16'd1, 16'd1, 1'b0);
        offer_pair(16'd1, MINUS_ONE, 1'b0);
        offer_pair(16'd1, MINUS_ONE, 1'b1);
        // mixed signs and alternating bit patterns
        offer_pair(16'd3, 16'd4, 1'b0);
        offer_pair(16'd4, -16'sd3, 1'b0);
        offer_pair(NEG_FULL, POS_FULL, 1'b1);
        offer_pair(16'd100, 16'd99, 1'b0);
        offer_pair(MINUS_ONE, MINUS_ONE, 1'b0);
        offer_pair(16'h5555, 16'hAAAA, 1'b1);
        settle();

        // Random vectors, mostly short
        pairs_sent = 0;
        vectors    = 0;
        while (pairs_sent < RANDOM_PAIRS) begin
            if (vectors == 20) begin
                // fill the core behind a stalled receiver
                hold_req = 1;
                for (int v = 0; v < 8; v++)
                    send_vector(3, pick_shape());
                pairs_sent += 24;
            end else if (vectors == 45) begin
                // one vector at the design length, streamed back to back
                steady = 1;
                send_vector(MAX_LENGTH, SHAPE_RANDOM);
                steady = 0;
                pairs_sent += MAX_LENGTH;
            end else begin
                if (vectors == 35)
                    settle();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                  : $urandom_range(1, 12);
                send_vector(len, pick_shape());
                pairs_sent += len;
            end
            vectors++;
        end
        settle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("cosine_distance_core_test passed");
        end else begin
            $display("cosine_distance_core_test failed");
        end
        $finish;
    end

endmodule
